>>> hw/rtl/dtse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtse_pkg;

	// operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_UP    = 2'd1;
	localparam logic [1:0] OP_DOWN  = 2'd2;
	localparam logic [1:0] OP_ENTER = 2'd3;

	// field codes; codes above FIELD_DONE act as done
	localparam logic [2:0] FIELD_YEAR   = 3'd0;
	localparam logic [2:0] FIELD_MONTH  = 3'd1;
	localparam logic [2:0] FIELD_DAY    = 3'd2;
	localparam logic [2:0] FIELD_HOUR   = 3'd3;
	localparam logic [2:0] FIELD_MINUTE = 3'd4;
	localparam logic [2:0] FIELD_DONE   = 3'd5;

	localparam logic [11:0] YEAR_RST  = 12'd2000;
	localparam logic [3:0]  MONTH_RST = 4'd1;
	localparam logic [4:0]  DAY_RST   = 5'd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [11:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
		logic [4:0]  load_hour;
		logic [5:0]  load_minute;
	} dtse_in_t;

	typedef struct packed {
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [2:0]  editing_field;
		logic        commit;
		logic        leave_menu;
	} dtse_out_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  field;
		logic        last_down;
	} dtse_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtse_edit.sv
`timescale 1ns / 1ps
`default_nettype none

module dtse_edit
	import dtse_pkg::*;
(
	input  wire dtse_state_t cur,
	input  wire dtse_in_t    cmd,
	output dtse_state_t nxt,
	output logic        commit,
	output logic        leave_menu
);

	logic [15:0] yr;
	logic [7:0]  mon;
	logic [7:0]  dy;
	logic [7:0]  hr;
	logic [7:0]  mn;
	logic [7:0]  len;
	logic        down;
	logic [15:0] d16;
	logic [7:0]  d8;

	function automatic logic [7:0] month_len(input logic [7:0] m, input logic [15:0] y);
		logic [7:0] r;
		begin
			if (m == 8'd2) begin
				r = (y[1:0] == 2'b00) ? 8'd29 : 8'd28;
			end else if (m == 8'd4 || m == 8'd6 || m == 8'd9 || m == 8'd11) begin
				r = 8'd30;
			end else begin
				r = 8'd31;
			end
			return r;
		end
	endfunction

	assign down = (cmd.operation == OP_DOWN);
	assign d16  = down ? 16'hFFFF : 16'h0001;
	assign d8   = down ? 8'hFF : 8'h01;

	// step the selected field, then recheck every field in order
	always_comb begin
		yr  = {4'd0, cur.year};
		mon = {4'd0, cur.month};
		dy  = {3'd0, cur.day};
		hr  = {3'd0, cur.hour};
		mn  = {2'd0, cur.minute};
		case (cur.field)
			FIELD_YEAR:   yr  = yr + d16;
			FIELD_MONTH:  mon = mon + d8;
			FIELD_DAY:    dy  = dy + d8;
			FIELD_HOUR:   hr  = hr + d8;
			FIELD_MINUTE: mn  = mn + d8;
			default: ;
		endcase
		if (mn == 8'hFF) begin
			mn = 8'd59;
			hr = hr - 8'd1;
		end
		if (mn > 8'd59) begin
			mn = 8'd0;
			hr = hr + 8'd1;
		end
		if (hr > 8'd23) hr = 8'd0;
		if (mon < 8'd1) mon = 8'd12;
		if (mon > 8'd12) mon = 8'd1;
		if (yr < 16'd2000) yr = 16'd2000;
		if (yr > 16'd3000) yr = 16'd3000;
		if (dy < 8'd1) dy = 8'd31;
		len = month_len(mon, yr);
		if (dy > len) dy = down ? len : 8'd1;
	end

	always_comb begin
		nxt        = cur;
		commit     = 1'b0;
		leave_menu = 1'b0;
		if (cmd.operation == OP_LOAD) begin
			nxt.year   = cmd.load_year;
			nxt.month  = cmd.load_month;
			nxt.day    = cmd.load_day;
			nxt.hour   = cmd.load_hour;
			nxt.minute = cmd.load_minute;
			nxt.field  = FIELD_YEAR;
		end else if (cur.field >= FIELD_DONE) begin
			leave_menu = 1'b1;
		end else if (cmd.operation == OP_ENTER) begin
			commit    = (cur.field == FIELD_MINUTE);
			nxt.field = cur.field + 3'd1;
		end else begin
			nxt.year      = yr[11:0];
			nxt.month     = mon[3:0];
			nxt.day       = dy[4:0];
			nxt.hour      = hr[4:0];
			nxt.minute    = mn[5:0];
			nxt.last_down = down;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/date_time_set_editor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Date and time set editor, driven by button words.
// Input channel cmd (cmd_valid/cmd_ready): one word per button event: load,
// up, down or enter, with the current date and time used by load.
// Output channel res (res_valid/res_ready): one word per accepted command,
// showing the edited date and time, the selected field, and the commit and
// leave_menu pulses caused by that command.
// The result word is registered: it is valid the cycle after the command is taken.
// Throughput: one command per cycle while res_ready stays high; the edit
// state is updated at the accepting edge by a single pass of wrap and
// clamp logic, so the next command sees it at once.
// cmd_ready is high while the result register is empty or being drained;
// when the receiver stalls, the result word holds and cmd_ready drops
// until it is taken.
// Reset: the edit state returns to 2000-01-01 00:00 with the year field
// selected, and no result word is pending.
module date_time_set_editor_core
	import dtse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire dtse_in_t  cmd,
	output logic           res_valid,
	input  wire logic      res_ready,
	output dtse_out_t      res
);

	dtse_state_t state_q;
	dtse_state_t state_nxt;
	logic        commit_nxt;
	logic        leave_nxt;
	logic        accept;
	dtse_out_t   res_q;
	logic        res_valid_q;

	dtse_edit u_edit (
		.cur        (state_q),
		.cmd        (cmd),
		.nxt        (state_nxt),
		.commit     (commit_nxt),
		.leave_menu (leave_nxt)
	);

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.year      <= YEAR_RST;
			state_q.month     <= MONTH_RST;
			state_q.day       <= DAY_RST;
			state_q.hour      <= '0;
			state_q.minute    <= '0;
			state_q.field     <= FIELD_YEAR;
			state_q.last_down <= 1'b0;
			res_valid_q       <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.year_out      <= state_nxt.year;
			res_q.month_out     <= state_nxt.month;
			res_q.day_out       <= state_nxt.day;
			res_q.hour_out      <= state_nxt.hour;
			res_q.minute_out    <= state_nxt.minute;
			res_q.editing_field <= state_nxt.field;
			res_q.commit        <= commit_nxt;
			res_q.leave_menu    <= leave_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid)
		else $error("accepted command produced no result word");

	a_commit_enters_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.commit) |-> (res.editing_field == FIELD_DONE))
		else $error("commit without entering done field");

	a_commit_leave_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.commit && res.leave_menu))
		else $error("commit and leave_menu in one word");

	a_leave_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.leave_menu) |-> (res.editing_field >= FIELD_DONE))
		else $error("leave_menu outside done field");

	a_state_matches_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.editing_field == state_q.field
			&& res.year_out == state_q.year))
		else $error("result word out of step with edit state");
`endif

endmodule

`default_nettype wire

>>> test/date_time_set_editor_core_test.sv
`timescale 1ns / 1ps

module date_time_set_editor_core_test
	import dtse_pkg::*;
();

	localparam int RANDOM_WORDS = 600;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 4;

	localparam logic [7:0]  LAST_MINUTE = 8'd59;
	localparam logic [7:0]  LAST_HOUR   = 8'd23;
	localparam logic [7:0]  MONTHS      = 8'd12;
	localparam logic [15:0] YEAR_MIN    = 16'd2000;
	localparam logic [15:0] YEAR_MAX    = 16'd3000;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	dtse_in_t  cmd       = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	dtse_out_t res;

	// edit state as the block should hold it
	logic [11:0] ed_year  = YEAR_RST;
	logic [3:0]  ed_month = MONTH_RST;
	logic [4:0]  ed_day   = DAY_RST;
	logic [4:0]  ed_hour  = '0;
	logic [5:0]  ed_minute = '0;
	logic [2:0]  ed_field = FIELD_YEAR;

	dtse_out_t edit_results_q[$];
	dtse_out_t want_word;
	int        mismatch_count = 0;
	int        words_sent = 0;
	int        tx_burst = 0;
	int        rx_burst = 0;
	int        rx_hold = 0;
	int        idle_cycles = 0;
	bit        running = 1'b0;

	date_time_set_editor_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] month_days(input logic [7:0] mon, input logic [15:0] yr);
		if (mon == 8'd2) begin
			return (yr[1:0] == 2'b00) ? 8'd29 : 8'd28;
		end
		if (mon == 8'd4 || mon == 8'd6 || mon == 8'd9 || mon == 8'd11) begin
			return 8'd30;
		end
		return 8'd31;
	endfunction

	// Advance the edit state by one button word and return the word it shows.
	function automatic dtse_out_t apply_button(input dtse_in_t w);
		dtse_out_t   r;
		logic [15:0] yr;
		logic [7:0]  mon, dy, hr, mn, len;
		logic        down;
		r = '0;
		if (w.operation == OP_LOAD) begin
			ed_year   = w.load_year;
			ed_month  = w.load_month;
			ed_day    = w.load_day;
			ed_hour   = w.load_hour;
			ed_minute = w.load_minute;
			ed_field  = FIELD_YEAR;
		end else if (ed_field >= FIELD_DONE) begin
			r.leave_menu = 1'b1;
		end else if (w.operation == OP_ENTER) begin
			if (ed_field == FIELD_MINUTE) begin
				r.commit = 1'b1;
			end
			ed_field = ed_field + 3'd1;
		end else begin
			down = (w.operation == OP_DOWN);
			yr  = {4'd0, ed_year};
			mon = {4'd0, ed_month};
			dy  = {3'd0, ed_day};
			hr  = {3'd0, ed_hour};
			mn  = {2'd0, ed_minute};
			case (ed_field)
				FIELD_YEAR: yr = down ? yr - 16'd1 : yr + 16'd1;
				FIELD_MONTH: mon = down ? mon - 8'd1 : mon + 8'd1;
				FIELD_DAY: dy = down ? dy - 8'd1 : dy + 8'd1;
				FIELD_HOUR: hr = down ? hr - 8'd1 : hr + 8'd1;
				FIELD_MINUTE: mn = down ? mn - 8'd1 : mn + 8'd1;
				default: ;
			endcase
			// minute borrow and carry reach the hour before it wraps
			if (mn == 8'hFF) begin
				mn = LAST_MINUTE;
				hr = hr - 8'd1;
			end
			if (mn > LAST_MINUTE) begin
				mn = 8'd0;
				hr = hr + 8'd1;
			end
			if (hr > LAST_HOUR) hr = 8'd0;
			if (mon < 8'd1) mon = MONTHS;
			if (mon > MONTHS) mon = 8'd1;
			if (yr < YEAR_MIN) yr = YEAR_MIN;
			if (yr > YEAR_MAX) yr = YEAR_MAX;
			if (dy < 8'd1) dy = 8'd31;
			len = month_days(mon, yr);
			if (dy > len) dy = down ? len : 8'd1;
			ed_year   = yr[11:0];
			ed_month  = mon[3:0];
			ed_day    = dy[4:0];
			ed_hour   = hr[4:0];
			ed_minute = mn[5:0];
		end
		r.year_out      = ed_year;
		r.month_out     = ed_month;
		r.day_out       = ed_day;
		r.hour_out      = ed_hour;
		r.minute_out    = ed_minute;
		r.editing_field = ed_field;
		return r;
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Load fields are random on every word; only load looks at them.
	function automatic dtse_in_t make_press(input logic [1:0] op);
		dtse_in_t w;
		w.operation   = op;
		w.load_year   = 12'($urandom);
		w.load_month  = 4'($urandom);
		w.load_day    = 5'($urandom);
		w.load_hour   = 5'($urandom);
		w.load_minute = 6'($urandom);
		return w;
	endfunction

	function automatic dtse_in_t make_load(input int yr, input int mon, input int dy,
			input int hr, input int mn);
		dtse_in_t w;
		w.operation   = OP_LOAD;
		w.load_year   = 12'(yr);
		w.load_month  = 4'(mon);
		w.load_day    = 5'(dy);
		w.load_hour   = 5'(hr);
		w.load_minute = 6'(mn);
		return w;
	endfunction

	function automatic dtse_in_t random_load();
		int yr, mon, dy, mn;
		// one load in five keeps the raw field values, out of range included
		if ($urandom_range(0, 4) == 0) return make_press(OP_LOAD);
		yr  = ($urandom_range(0, 2) == 0) ? 4 * $urandom_range(499, 751) :
			$urandom_range(1996, 3004);
		mon = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(1, 12);
		dy  = ($urandom_range(0, 1) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 31);
		mn  = ($urandom_range(0, 3) == 0) ? 59 * $urandom_range(0, 1) : $urandom_range(0, 59);
		return make_load(yr, mon, dy, $urandom_range(0, 23), mn);
	endfunction

	task automatic send_word(input dtse_in_t w);
		int gap;
		if (tx_burst > 0) begin
			tx_burst--;
			gap = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			tx_burst = $urandom_range(10, 60);
			gap = 0;
		end else begin
			gap = random_gap();
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		edit_results_q.push_back(apply_button(w));
		words_sent++;
	endtask

	task automatic press(input logic [1:0] op);
		send_word(make_press(op));
	endtask

	// Receiver: stall at random, with stretches of steady ready.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			res_ready <= 1'b0;
		end else if (rx_burst > 0) begin
			rx_burst <= rx_burst - 1;
			res_ready <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			rx_burst <= $urandom_range(20, 80);
			res_ready <= 1'b1;
		end else begin
			rx_hold <= random_gap();
			res_ready <= ($urandom_range(0, 1) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (edit_results_q.size() == 0) begin
				report_mismatch("result word with nothing expected",
					int'(res.year_out), 0);
			end else begin
				want_word = edit_results_q.pop_front();
				if (res.year_out !== want_word.year_out)
					report_mismatch("year_out", int'(res.year_out),
						int'(want_word.year_out));
				if (res.month_out !== want_word.month_out)
					report_mismatch("month_out", int'(res.month_out),
						int'(want_word.month_out));
				if (res.day_out !== want_word.day_out)
					report_mismatch("day_out", int'(res.day_out),
						int'(want_word.day_out));
				if (res.hour_out !== want_word.hour_out)
					report_mismatch("hour_out", int'(res.hour_out),
						int'(want_word.hour_out));
				if (res.minute_out !== want_word.minute_out)
					report_mismatch("minute_out", int'(res.minute_out),
						int'(want_word.minute_out));
				if (res.editing_field !== want_word.editing_field)
					report_mismatch("editing_field", int'(res.editing_field),
						int'(want_word.editing_field));
				if (res.commit !== want_word.commit)
					report_mismatch("commit", int'(res.commit),
						int'(want_word.commit));
				if (res.leave_menu !== want_word.leave_menu)
					report_mismatch("leave_menu", int'(res.leave_menu),
						int'(want_word.leave_menu));
			end
		end
	end

	// Drop the run if neither side moves a word for too long.
	always @(posedge clk) begin
		if (running) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic test_load_extremes();
		press(OP_UP);
		press(OP_DOWN);
		// year 0 minus one wraps past the top clamp; every other field is out of range
		send_word(make_load(0, 0, 0, 31, 63));
		press(OP_DOWN);
		send_word(make_load(4095, 15, 31, 31, 63));
		press(OP_UP);
	endtask

	task automatic test_calendar_fit();
		send_word(make_load(2000, 2, 29, 12, 30));
		press(OP_ENTER);
		press(OP_UP);
		press(OP_DOWN);
		press(OP_ENTER);
		press(OP_UP);
		press(OP_DOWN);
		// month 0 decremented wraps to the top of 8 bits and lands on 1
		send_word(make_load(2010, 0, 15, 12, 30));
		press(OP_ENTER);
		press(OP_DOWN);
	endtask

	task automatic test_time_carry();
		send_word(make_load(2010, 5, 5, 0, 0));
		repeat (3) press(OP_ENTER);
		press(OP_DOWN);
		press(OP_ENTER);
		press(OP_DOWN);
		press(OP_UP);
	endtask

	task automatic test_done_state();
		press(OP_ENTER);
		press(OP_UP);
		press(OP_DOWN);
		press(OP_ENTER);
		send_word(make_load(2024, 2, 29, 23, 59));
	endtask

	task automatic run_session();
		int       steps;
		int       bias;
		logic [1:0] op;
		send_word(random_load());
		for (int f = 0; f < 5; f++) begin
			steps = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 4);
			bias  = $urandom_range(0, 2);
			for (int s = 0; s < steps; s++) begin
				if (bias == 2) op = ($urandom_range(0, 1) == 0) ? OP_UP : OP_DOWN;
				else op = (bias == 0) ? OP_UP : OP_DOWN;
				press(op);
			end
			// cut the sequence short now and then
			if ($urandom_range(0, 24) == 0) return;
			press(OP_ENTER);
		end
		repeat ($urandom_range(0, 3)) press(2'(OP_UP + $urandom_range(0, 2)));
	endtask

	task automatic test_random_sessions();
		int stop_at;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) press(2'($urandom_range(0, 3)));
			else run_session();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;
		test_load_extremes();
		test_calendar_fit();
		test_time_carry();
		test_done_state();
		test_random_sessions();
		cmd_valid <= 1'b0;
		while (edit_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> date_time_set_editor_core.f
hw/rtl/dtse_pkg.sv
hw/rtl/dtse_edit.sv
hw/rtl/date_time_set_editor_core.sv
test/date_time_set_editor_core_test.sv
